FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// each macro clocks on i_clk; the first one is also held off while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, off during reset
`define FFPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define FFPA_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/ffpa_pkg.sv
// shared types, codes and default sizes of the pool allocator
// used by first_fit_pool_allocator and its checker; depends on nothing
`default_nettype none

package ffpa_pkg;

    // default geometry
    localparam int POOL_MAX_BYTES_DEF = 65536;
    localparam int HEADER_BYTES_DEF   = 16;
    localparam int MIN_PAYLOAD_DEF    = 32;
    localparam int NUM_POOLS_DEF      = 3;

    // fixed widths and limits
    localparam int GRANULE_BYTES = 8;
    localparam int CFG_POOLS     = 3;
    localparam int CFG_AW        = 5;
    localparam int STAT_W        = 17;
    localparam int CNT_W         = 32;
    localparam int NEED_W        = 18;
    localparam logic [STAT_W-1:0] STAT_MAX = 17'h1FFFF;

    // commands
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;
    localparam logic [1:0] CMD_STATS = 2'd3;

    // result status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_BAD_ARG   = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_DOUBLE    = 3'd4;
    localparam logic [2:0] ST_BAD_ALIGN = 3'd5;

    // register indexes
    localparam logic [2:0] REG_CODE_BYTES = 3'd0;
    localparam logic [2:0] REG_DATA_BYTES = 3'd1;
    localparam logic [2:0] REG_META_BYTES = 3'd2;
    localparam logic [2:0] REG_CODE_BASE  = 3'd3;
    localparam logic [2:0] REG_DATA_BASE  = 3'd4;
    localparam logic [2:0] REG_META_BASE  = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  pool_select;
        logic [16:0] request_bytes;
        logic [16:0] align_bytes;
        logic [15:0] user_offset_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] user_offset_out;
        logic [16:0] used_bytes;
        logic [16:0] free_bytes;
        logic [16:0] peak_bytes;
        logic [31:0] alloc_count;
        logic [31:0] release_count;
    } t_out_item;

endpackage

`default_nettype wire

FILE: rtl/core/ffpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// standalone, no package needed
`default_nettype none

module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/first_fit_pool_allocator.sv
// first-fit pool allocator: alloc walks the header ram block by block (read, check), then writes a split-off
// tail block if the fit splits and then the taken header; free reads, checks and writes the header, then runs a
// merge walk that probes the successor of each free block and merges it (rewrite, then clear its header) when free,
// pool reset sweeps GRANULES entries (8192 at defaults), stats go straight to the result.
// sync reset (i_rst_n low) sets sizes and stats, then a clearing pass over
// NUM_POOLS*GRANULES entries (24576 at defaults) runs with the input stalled;
// a pool-size write clears that pool the same way. one item is worked at a time.
`default_nettype none

module first_fit_pool_allocator #(
    parameter int POOL_MAX_BYTES = ffpa_pkg::POOL_MAX_BYTES_DEF,
    parameter int HEADER_BYTES   = ffpa_pkg::HEADER_BYTES_DEF,
    parameter int MIN_PAYLOAD    = ffpa_pkg::MIN_PAYLOAD_DEF,
    parameter int NUM_POOLS      = ffpa_pkg::NUM_POOLS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ffpa_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // command channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  ffpa_pkg::t_in_item        i_in_item,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output ffpa_pkg::t_out_item       o_out_item
);

    import ffpa_pkg::*;

    localparam int NP       = (NUM_POOLS < CFG_POOLS) ? NUM_POOLS : CFG_POOLS;
    localparam int PW       = (NP > 1) ? $clog2(NP) : 1;
    localparam int GRANULES = POOL_MAX_BYTES / GRANULE_BYTES;
    localparam int GW       = $clog2(GRANULES);
    localparam int OW       = $clog2(POOL_MAX_BYTES + 1);
    localparam int CW       = ((OW > NEED_W) ? OW : NEED_W) + 2;
    localparam int HW       = OW + 2;
    localparam int DEPTH    = NP * GRANULES;
    localparam int AW       = $clog2(DEPTH);
    localparam int RST_BYTES = (POOL_MAX_BYTES < 65536) ? POOL_MAX_BYTES : 65536;
    localparam int MIN_POOL  = HEADER_BYTES + MIN_PAYLOAD;

    // states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_ARD   = 4'd2;
    localparam logic [3:0] S_ACHK  = 4'd3;
    localparam logic [3:0] S_ASPL  = 4'd4;
    localparam logic [3:0] S_AWR   = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_FCHK  = 4'd7;
    localparam logic [3:0] S_FWR   = 4'd8;
    localparam logic [3:0] S_MRD   = 4'd9;
    localparam logic [3:0] S_MCHK  = 4'd10;
    localparam logic [3:0] S_MNRD  = 4'd11;
    localparam logic [3:0] S_MNCHK = 4'd12;
    localparam logic [3:0] S_MWR   = 4'd13;
    localparam logic [3:0] S_MINV  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    typedef struct packed {
        logic          valid;
        logic          free;
        logic [OW-1:0] size;
    } t_hdr;

    // ram address of the header at a byte offset of a pool
    function automatic logic [AW-1:0] mem_addr(input logic [1:0] p, input logic [CW-1:0] off);
        logic [AW-1:0] row;
        row = AW'(AW'(p) * AW'(GRANULES));
        return row + AW'(off[GW+2:3]);
    endfunction

    function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
                                                  input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = (CW+1)'(a) + (CW+1)'(b);
        return (sum > (CW+1)'(STAT_MAX)) ? STAT_MAX : STAT_W'(sum);
    endfunction

    function automatic logic [STAT_W-1:0] sat_sub(input logic [STAT_W-1:0] a,
                                                  input logic [CW-1:0] b);
        logic [CW-1:0] diff;
        diff = CW'(a) - b;
        return (b > CW'(a)) ? '0 : STAT_W'(diff);
    endfunction

    // control registers
    logic [3:0]        r_state, n_state;
    logic [NP-1:0]     r_pend, n_pend;
    logic              r_clr_ret, n_clr_ret;
    logic [PW-1:0]     r_clr_pool, n_clr_pool;
    logic [GW-1:0]     r_clr_cnt, n_clr_cnt;
    logic              r_ov, n_ov;
    logic [OW-1:0]     r_pool_bytes [CFG_POOLS];
    logic [OW-1:0]     n_pool_bytes [CFG_POOLS];
    logic [31:0]       r_pool_base [CFG_POOLS];
    logic [31:0]       n_pool_base [CFG_POOLS];
    logic [STAT_W-1:0] r_used [NP], n_used [NP];
    logic [STAT_W-1:0] r_freeb [NP], n_freeb [NP];
    logic [STAT_W-1:0] r_peak [NP], n_peak [NP];
    logic [CNT_W-1:0]  r_allocs [NP], n_allocs [NP];
    logic [CNT_W-1:0]  r_frees [NP], n_frees [NP];

    // working registers of the current item
    logic [1:0]        r_pool, n_pool;
    logic              r_bad, n_bad;
    logic [2:0]        r_status, n_status;
    logic [15:0]       r_uoff, n_uoff;
    logic [NEED_W-1:0] r_need, n_need;
    logic [16:0]       r_align, n_align;
    logic [16:0]       r_base17, n_base17;
    logic [OW-1:0]     r_lim, n_lim;
    logic [CW-1:0]     r_cur, n_cur;
    logic [CW-1:0]     r_nxt, n_nxt;
    logic [OW-1:0]     r_hsize, n_hsize;
    t_out_item         r_out, n_out;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    t_hdr          ram_wdata, rd_hdr;

    ffpa_ram #(
        .WIDTH (HW),
        .DEPTH (DEPTH)
    ) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_hdr)
    );

    // handshakes
    logic in_xfer, out_xfer, cfg_we;
    logic [2:0] cfg_idx;
    assign o_in_stall  = (r_state != S_IDLE) || (r_pend != '0);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign out_xfer    = r_ov && !i_out_stall;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign cfg_we      = psel && penable && pwrite;
    assign cfg_idx     = paddr[4:2];

    // register read-back
    always_comb begin
        unique case (cfg_idx)
            REG_CODE_BYTES: prdata = 32'(r_pool_bytes[0]);
            REG_DATA_BYTES: prdata = 32'(r_pool_bytes[1]);
            REG_META_BYTES: prdata = 32'(r_pool_bytes[2]);
            REG_CODE_BASE:  prdata = r_pool_base[0];
            REG_DATA_BASE:  prdata = r_pool_base[1];
            REG_META_BASE:  prdata = r_pool_base[2];
            default:        prdata = '0;
        endcase
    end

    // walk arithmetic on the header just read
    logic [CW-1:0] lim, blk_end, hsz_end;
    logic [16:0]   a_addr, a_mask;
    logic          aligned;
    logic [PW-1:0] si;
    assign lim     = CW'(r_lim);
    assign blk_end = r_cur + CW'(HEADER_BYTES) + CW'(rd_hdr.size);
    assign hsz_end = r_cur + CW'(HEADER_BYTES) + CW'(r_hsize);
    assign a_addr  = r_base17 + 17'(r_cur) + 17'(HEADER_BYTES);
    assign a_mask  = r_align - 17'd1;
    assign aligned = (r_align == '0) || ((a_addr & a_mask) == '0);
    assign si      = r_pool[PW-1:0];

    // accept-time decode
    t_in_item      in;
    logic          pool_ok, align_bad;
    logic [OW-1:0] sel_bytes;
    logic [31:0]   sel_base;
    logic [NEED_W-1:0] need;
    logic [CW-1:0] ho;
    logic          free_bad;
    assign in = i_in_item;

    always_comb begin
        sel_bytes = r_pool_bytes[0];
        sel_base  = r_pool_base[0];
        for (int i = 0; i < CFG_POOLS; i++) begin
            if (in.pool_select == 2'(i)) begin
                sel_bytes = r_pool_bytes[i];
                sel_base  = r_pool_base[i];
            end
        end
        pool_ok   = 3'(in.pool_select) < 3'(NP);
        align_bad = (in.align_bytes != '0) &&
                    ((in.align_bytes & (in.align_bytes - 17'd1)) != '0);
        need      = (in.request_bytes < 17'(MIN_PAYLOAD)) ? NEED_W'(MIN_PAYLOAD) :
                    ((NEED_W'(in.request_bytes) + NEED_W'(7)) & ~NEED_W'(7));
        ho        = CW'(in.user_offset_in) - CW'(HEADER_BYTES);
        free_bad  = (in.user_offset_in < 16'(HEADER_BYTES)) || (ho[2:0] != 3'd0) ||
                    (ho >= CW'(sel_bytes));
    end

    // lowest pending clear
    logic [PW-1:0] pend_pick;
    always_comb begin
        pend_pick = '0;
        for (int i = NP - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                pend_pick = PW'(i);
            end
        end
    end

    // config write value, rounded and clamped
    logic [31:0] cfg_v;
    always_comb begin
        cfg_v = {15'd0, pwdata[16:3], 3'd0};
        if (cfg_v > 32'(POOL_MAX_BYTES)) begin
            cfg_v = 32'(POOL_MAX_BYTES);
        end
        if (cfg_v < 32'(MIN_POOL)) begin
            cfg_v = 32'(MIN_POOL);
        end
    end

    // main sequencer
    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_clr_ret    = r_clr_ret;
        n_clr_pool   = r_clr_pool;
        n_clr_cnt    = r_clr_cnt;
        n_ov         = r_ov;
        n_pool_bytes = r_pool_bytes;
        n_pool_base  = r_pool_base;
        n_used       = r_used;
        n_freeb      = r_freeb;
        n_peak       = r_peak;
        n_allocs     = r_allocs;
        n_frees      = r_frees;
        n_pool       = r_pool;
        n_bad        = r_bad;
        n_status     = r_status;
        n_uoff       = r_uoff;
        n_need       = r_need;
        n_align      = r_align;
        n_base17     = r_base17;
        n_lim        = r_lim;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_hsize      = r_hsize;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = mem_addr(r_pool, r_cur);
        ram_wdata    = '0;
        ram_raddr    = mem_addr(r_pool, r_cur);

        if (out_xfer) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (r_pend != '0) begin
                    n_clr_pool = pend_pick;
                    n_pend[pend_pick] = 1'b0;
                    n_clr_cnt  = '0;
                    n_state    = S_CLR;
                end else if (in_xfer) begin
                    n_pool   = in.pool_select;
                    n_bad    = !pool_ok;
                    n_status = ST_OK;
                    n_uoff   = '0;
                    n_need   = need;
                    n_align  = in.align_bytes;
                    n_base17 = sel_base[16:0];
                    n_lim    = sel_bytes;
                    n_cur    = '0;
                    if (!pool_ok) begin
                        n_status = ST_BAD_ARG;
                        n_state  = S_OUT;
                    end else begin
                        case (in.cmd)
                            CMD_ALLOC: begin
                                if (align_bad) begin
                                    n_status = ST_BAD_ALIGN;
                                    n_state  = S_OUT;
                                end else if (in.request_bytes == '0) begin
                                    n_status = ST_BAD_ARG;
                                    n_state  = S_OUT;
                                end else begin
                                    n_state = S_ARD;
                                end
                            end
                            CMD_FREE: begin
                                n_cur = ho;
                                if (free_bad) begin
                                    n_status = ST_BAD_HDR;
                                    n_state  = S_OUT;
                                end else begin
                                    n_state = S_FRD;
                                end
                            end
                            CMD_RESET: begin
                                n_used[in.pool_select[PW-1:0]]   = '0;
                                n_freeb[in.pool_select[PW-1:0]]  =
                                    STAT_W'(CW'(sel_bytes) - CW'(HEADER_BYTES));
                                n_allocs[in.pool_select[PW-1:0]] = '0;
                                n_frees[in.pool_select[PW-1:0]]  = '0;
                                n_clr_pool = in.pool_select[PW-1:0];
                                n_clr_cnt  = '0;
                                n_clr_ret  = 1'b1;
                                n_state    = S_CLR;
                            end
                            default: begin
                                n_state = S_OUT;
                            end
                        endcase
                    end
                end
            end

            // clearing sweep, entry 0 gets the single free block
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = mem_addr(2'(r_clr_pool), CW'({r_clr_cnt, 3'd0}));
                if (r_clr_cnt == '0) begin
                    ram_wdata.valid = 1'b1;
                    ram_wdata.free  = 1'b1;
                    ram_wdata.size  = r_pool_bytes[r_clr_pool] - OW'(HEADER_BYTES);
                end
                n_clr_cnt = r_clr_cnt + GW'(1);
                if (r_clr_cnt == GW'(GRANULES - 1)) begin
                    if (r_pend != '0) begin
                        n_clr_pool = pend_pick;
                        n_pend[pend_pick] = 1'b0;
                        n_clr_cnt  = '0;
                    end else if (r_clr_ret) begin
                        n_clr_ret = 1'b0;
                        n_state   = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            // first-fit walk
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (!rd_hdr.valid || blk_end > lim) begin
                    n_status = ST_BAD_HDR;
                    n_state  = S_OUT;
                end else if (rd_hdr.free && CW'(rd_hdr.size) >= CW'(r_need) && aligned) begin
                    n_hsize = rd_hdr.size;
                    if (CW'(rd_hdr.size) >= CW'(r_need) + CW'(HEADER_BYTES + MIN_PAYLOAD)) begin
                        n_state = S_ASPL;
                    end else begin
                        n_state = S_AWR;
                    end
                end else begin
                    n_cur = blk_end;
                    if (blk_end >= lim) begin
                        n_status = ST_NO_FIT;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_ARD;
                    end
                end
            end
            S_ASPL: begin
                ram_we          = 1'b1;
                ram_waddr       = mem_addr(r_pool, r_cur + CW'(HEADER_BYTES) + CW'(r_need));
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.size  = OW'(CW'(r_hsize) - CW'(r_need) - CW'(HEADER_BYTES));
                n_hsize         = OW'(r_need);
                n_state         = S_AWR;
            end
            S_AWR: begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b0;
                ram_wdata.size  = r_hsize;
                n_used[si]   = sat_add(r_used[si], CW'(r_hsize) + CW'(HEADER_BYTES));
                n_freeb[si]  = sat_sub(r_freeb[si], CW'(r_hsize) + CW'(HEADER_BYTES));
                n_allocs[si] = r_allocs[si] + CNT_W'(1);
                if (n_used[si] > r_peak[si]) begin
                    n_peak[si] = n_used[si];
                end
                n_uoff   = 16'(r_cur + CW'(HEADER_BYTES));
                n_status = ST_OK;
                n_state  = S_OUT;
            end

            // release
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                n_hsize = rd_hdr.size;
                if (!rd_hdr.valid) begin
                    n_status = ST_BAD_HDR;
                    n_state  = S_OUT;
                end else if (rd_hdr.free) begin
                    n_status = ST_DOUBLE;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_FWR;
                end
            end
            S_FWR: begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.size  = r_hsize;
                n_used[si]  = sat_sub(r_used[si], CW'(r_hsize) + CW'(HEADER_BYTES));
                n_freeb[si] = sat_add(r_freeb[si], CW'(r_hsize) + CW'(HEADER_BYTES));
                n_frees[si] = r_frees[si] + CNT_W'(1);
                n_cur       = '0;
                n_state     = S_MRD;
            end

            // merge pass
            S_MRD: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (!rd_hdr.valid || blk_end > lim) begin
                    n_state = S_OUT;
                end else if (rd_hdr.free && blk_end < lim) begin
                    n_nxt   = blk_end;
                    n_hsize = rd_hdr.size;
                    n_state = S_MNRD;
                end else begin
                    n_cur = blk_end;
                    n_state = (blk_end >= lim) ? S_OUT : S_MRD;
                end
            end
            S_MNRD: begin
                ram_raddr = mem_addr(r_pool, r_nxt);
                n_state   = S_MNCHK;
            end
            S_MNCHK: begin
                if (rd_hdr.valid && rd_hdr.free) begin
                    n_hsize = OW'(CW'(r_hsize) + CW'(HEADER_BYTES) + CW'(rd_hdr.size));
                    n_state = S_MWR;
                end else begin
                    n_cur   = r_nxt;
                    n_state = S_MRD;
                end
            end
            S_MWR: begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.size  = r_hsize;
                n_state         = S_MINV;
            end
            S_MINV: begin
                ram_we    = 1'b1;
                ram_waddr = mem_addr(r_pool, r_nxt);
                n_cur     = hsz_end;
                n_state   = (hsz_end >= lim) ? S_OUT : S_MRD;
            end

            // result register load
            S_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_out        = '0;
                    n_out.status = r_status;
                    if (!r_bad) begin
                        n_out.user_offset_out = r_uoff;
                        n_out.used_bytes      = r_used[si];
                        n_out.free_bytes      = r_freeb[si];
                        n_out.peak_bytes      = r_peak[si];
                        n_out.alloc_count     = r_allocs[si];
                        n_out.release_count   = r_frees[si];
                    end
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration transfer
        if (cfg_we) begin
            if (cfg_idx == REG_CODE_BYTES || cfg_idx == REG_DATA_BYTES ||
                cfg_idx == REG_META_BYTES) begin
                n_pool_bytes[cfg_idx[1:0]] = OW'(cfg_v);
                for (int i = 0; i < NP; i++) begin
                    if (cfg_idx[1:0] == 2'(i)) begin
                        n_pend[i]   = 1'b1;
                        n_used[i]   = '0;
                        n_freeb[i]  = STAT_W'(cfg_v - 32'(HEADER_BYTES));
                        n_peak[i]   = '0;
                        n_allocs[i] = '0;
                        n_frees[i]  = '0;
                    end
                end
            end else if (cfg_idx == REG_CODE_BASE || cfg_idx == REG_DATA_BASE ||
                         cfg_idx == REG_META_BASE) begin
                n_pool_base[2'(cfg_idx - REG_CODE_BASE)] = pwdata;
            end
        end
    end

    // control and statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= '1;
            r_clr_ret <= 1'b0;
            r_ov      <= 1'b0;
            for (int i = 0; i < CFG_POOLS; i++) begin
                r_pool_bytes[i] <= OW'(RST_BYTES);
                r_pool_base[i]  <= '0;
            end
            for (int i = 0; i < NP; i++) begin
                r_used[i]   <= '0;
                r_freeb[i]  <= STAT_W'(RST_BYTES - HEADER_BYTES);
                r_peak[i]   <= '0;
                r_allocs[i] <= '0;
                r_frees[i]  <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_clr_ret    <= n_clr_ret;
            r_ov         <= n_ov;
            r_pool_bytes <= n_pool_bytes;
            r_pool_base  <= n_pool_base;
            r_used       <= n_used;
            r_freeb      <= n_freeb;
            r_peak       <= n_peak;
            r_allocs     <= n_allocs;
            r_frees      <= n_frees;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_clr_pool <= n_clr_pool;
        r_clr_cnt  <= n_clr_cnt;
        r_pool     <= n_pool;
        r_bad      <= n_bad;
        r_status   <= n_status;
        r_uoff     <= n_uoff;
        r_need     <= n_need;
        r_align    <= n_align;
        r_base17   <= n_base17;
        r_lim      <= n_lim;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_hsize    <= n_hsize;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/core/ffpa_checker.sv
// port-level checks for first_fit_pool_allocator, bound to the top level
// depends on ffpa_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ffpa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ffpa_pkg::t_out_item o_out_item
);

    import ffpa_pkg::*;

    // a stalled result stays put
    `FFPA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item), "result dropped or changed under stall")

    // the clearing pass holds off commands after reset
    `FFPA_ASSERT_NR(a_rst_stall, !i_rst_n |=> o_in_stall, "command accepted during clearing pass")

    // one command at a time
    `FFPA_ASSERT(a_busy_after_xfer, i_in_valid && !o_in_stall |=> o_in_stall, "second command taken while busy")

    // only a good allocation carries an offset
    `FFPA_ASSERT(a_offset_on_error, o_out_valid && o_out_item.status != ST_OK |-> o_out_item.user_offset_out == '0, "offset on failed command")

    // peak never below usage
    `FFPA_ASSERT(a_peak_covers_used, o_out_valid |-> o_out_item.peak_bytes >= o_out_item.used_bytes, "peak below used bytes")

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (.*);

`default_nettype wire

FILE: test/tb_first_fit_pool_allocator.sv
// testbench for first_fit_pool_allocator: random and directed pool commands
// checked against a behavioral model of the three pools; uses ffpa_pkg
`default_nettype none

module tb_first_fit_pool_allocator;
    import ffpa_pkg::*;

    localparam int GRAN_N   = 8192;
    localparam int HDR      = 16;
    localparam int MINPAY   = 32;
    localparam int WD_LIMIT = 200000;

    // allocator model with the queue of expected results
    class pool_model;
        bit          hv[3][GRAN_N];
        bit          hf[3][GRAN_N];
        int unsigned hs[3][GRAN_N];
        int unsigned pbytes[3], pbase[3];
        int unsigned used_s[3], free_s[3], peak_s[3], alloc_s[3], rel_s[3];
        int unsigned live[3][$];
        int unsigned last_freed[3];
        t_out_item   pending_results[$];
        int          errors, checked, good_allocs, good_frees;

        function new();
            for (int p = 0; p < 3; p++) begin
                pbytes[p] = 65536;
                pbase[p] = 0;
                peak_s[p] = 0;
                last_freed[p] = 16;
                clear_pool(p);
            end
        endfunction

        function void clear_pool(int p);
            for (int g = 0; g < GRAN_N; g++) begin
                hv[p][g] = 0;
                hf[p][g] = 0;
                hs[p][g] = 0;
            end
            hv[p][0] = 1;
            hf[p][0] = 1;
            hs[p][0] = pbytes[p] - HDR;
            used_s[p] = 0;
            free_s[p] = pbytes[p] - HDR;
            alloc_s[p] = 0;
            rel_s[p] = 0;
            live[p].delete();
        endfunction

        function int unsigned sat_add(int unsigned a, int unsigned b);
            return (a + b > 131071) ? 131071 : a + b;
        endfunction

        function int unsigned sat_sub(int unsigned a, int unsigned b);
            return (b > a) ? 0 : a - b;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            int unsigned v;
            if (idx < REG_CODE_BASE) begin
                v = (val & 32'h1FFFF) & ~32'd7;
                if (v > 65536) v = 65536;
                if (v < HDR + MINPAY) v = HDR + MINPAY;
                pbytes[idx] = v;
                peak_s[idx] = 0;
                clear_pool(idx);
            end else begin
                pbase[idx - REG_CODE_BASE] = val;
            end
        endfunction

        // one merge pass over the chain after a release
        function void merge_free(int p);
            int unsigned cur, nxt, g, n;
            cur = 0;
            while (cur < pbytes[p] && cur / 8 < GRAN_N) begin
                g = cur / 8;
                if (!hv[p][g] || longint'(cur) + HDR + hs[p][g] > pbytes[p]) return;
                if (hf[p][g]) begin
                    nxt = cur + HDR + hs[p][g];
                    if (nxt < pbytes[p] && nxt / 8 < GRAN_N) begin
                        n = nxt / 8;
                        if (hv[p][n] && hf[p][n]) begin
                            hs[p][g] += HDR + hs[p][n];
                            hv[p][n] = 0;
                            hf[p][n] = 0;
                            hs[p][n] = 0;
                        end
                    end
                end
                cur = cur + HDR + hs[p][g];
            end
        endfunction

        function logic [2:0] alloc_block(int p, int unsigned req, int unsigned al,
                                         output int unsigned uoff);
            int unsigned need, cur, g, n, charge;
            longint addr;
            uoff = 0;
            if (al != 0 && (al & (al - 1)) != 0) return ST_BAD_ALIGN;
            if (req == 0) return ST_BAD_ARG;
            need = (req < MINPAY) ? MINPAY : ((req + 7) & ~32'd7);
            cur = 0;
            while (cur < pbytes[p] && cur / 8 < GRAN_N) begin
                g = cur / 8;
                if (!hv[p][g] || longint'(cur) + HDR + hs[p][g] > pbytes[p])
                    return ST_BAD_HDR;
                if (hf[p][g] && hs[p][g] >= need) begin
                    addr = longint'(pbase[p]) + cur + HDR;
                    if (al == 0 || (addr & longint'(al - 1)) == 0) begin
                        // split off the tail when a useful block remains
                        if (hs[p][g] >= need + HDR + MINPAY) begin
                            n = ((cur + HDR + need) / 8) % GRAN_N;
                            hv[p][n] = 1;
                            hf[p][n] = 1;
                            hs[p][n] = hs[p][g] - need - HDR;
                            hs[p][g] = need;
                        end
                        hf[p][g] = 0;
                        charge = hs[p][g] + HDR;
                        used_s[p] = sat_add(used_s[p], charge);
                        free_s[p] = sat_sub(free_s[p], charge);
                        alloc_s[p] += 1;
                        if (used_s[p] > peak_s[p]) peak_s[p] = used_s[p];
                        uoff = cur + HDR;
                        return ST_OK;
                    end
                end
                cur = cur + HDR + hs[p][g];
            end
            return ST_NO_FIT;
        endfunction

        function logic [2:0] release_block(int p, int unsigned uoff);
            int unsigned ho, g, charge;
            if (uoff < HDR) return ST_BAD_HDR;
            ho = uoff - HDR;
            if (ho % 8 != 0 || ho >= pbytes[p] || ho / 8 >= GRAN_N) return ST_BAD_HDR;
            g = ho / 8;
            if (!hv[p][g]) return ST_BAD_HDR;
            if (hf[p][g]) return ST_DOUBLE;
            hf[p][g] = 1;
            charge = hs[p][g] + HDR;
            used_s[p] = sat_sub(used_s[p], charge);
            free_s[p] = sat_add(free_s[p], charge);
            rel_s[p] += 1;
            merge_free(p);
            return ST_OK;
        endfunction

        // note an accepted command and queue its expected result
        function void note_command(t_in_item it);
            t_out_item r;
            int unsigned uoff;
            int p;
            r = '0;
            p = it.pool_select;
            if (p < 3) begin
                uoff = 0;
                case (it.cmd)
                    CMD_ALLOC: begin
                        r.status = alloc_block(p, it.request_bytes, it.align_bytes, uoff);
                        if (r.status == ST_OK) begin
                            live[p].push_back(uoff);
                            good_allocs++;
                        end
                    end
                    CMD_FREE: begin
                        r.status = release_block(p, it.user_offset_in);
                        if (r.status == ST_OK) begin
                            foreach (live[p][k])
                                if (live[p][k] == it.user_offset_in) begin
                                    live[p].delete(k);
                                    break;
                                end
                            last_freed[p] = it.user_offset_in;
                            good_frees++;
                        end
                    end
                    CMD_RESET: clear_pool(p);
                    default: ;
                endcase
                r.user_offset_out = uoff[15:0];
                r.used_bytes = used_s[p][16:0];
                r.free_bytes = free_s[p][16:0];
                r.peak_bytes = peak_s[p][16:0];
                r.alloc_count = alloc_s[p];
                r.release_count = rel_s[p];
            end else begin
                r.status = ST_BAD_ARG;
            end
            pending_results.push_back(r);
        endfunction

        task report(string field, longint got, longint want);
            $display("mismatch on %s: got %0h, expected %0h", field, got, want);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item w;
            if (pending_results.size() == 0) begin
                $display("unexpected result transfer, status %0d", got.status);
                errors++;
                return;
            end
            w = pending_results.pop_front();
            checked++;
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.user_offset_out !== w.user_offset_out)
                report("user_offset_out", got.user_offset_out, w.user_offset_out);
            if (got.used_bytes !== w.used_bytes)
                report("used_bytes", got.used_bytes, w.used_bytes);
            if (got.free_bytes !== w.free_bytes)
                report("free_bytes", got.free_bytes, w.free_bytes);
            if (got.peak_bytes !== w.peak_bytes)
                report("peak_bytes", got.peak_bytes, w.peak_bytes);
            if (got.alloc_count !== w.alloc_count)
                report("alloc_count", got.alloc_count, w.alloc_count);
            if (got.release_count !== w.release_count)
                report("release_count", got.release_count, w.release_count);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_out_item   o_out_item;

    pool_model   sb = new();
    bit          idle_on = 1;
    bit          hold_req = 0;
    int          n_sent = 0;
    int          quiet_cycles = 0;

    first_fit_pool_allocator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("timeout with %0d results outstanding", sb.pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall per transfer, one long hold on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                n = 3000;
                hold_req = 0;
            end else begin
                n = idle_on ? $urandom_range(0, 16) : 0;
            end
            if (n > 0) begin
                i_out_stall <= 1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            sb.check_result(o_out_item);
        end
    end

    task automatic send_cmd(t_in_item it);
        int gap;
        i_in_valid <= 1;
        i_in_item <= it;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note_command(it);
        n_sent++;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.write_reg(idx, val);
    endtask

    function automatic int unsigned pick_live(int p);
        if (sb.live[p].size() == 0) return $urandom_range(0, 65535);
        return sb.live[p][$urandom_range(0, sb.live[p].size() - 1)];
    endfunction

    function automatic t_in_item mk(logic [1:0] c, logic [1:0] p, int unsigned req,
                                    int unsigned al, int unsigned uo);
        t_in_item it;
        it.cmd = c;
        it.pool_select = p;
        it.request_bytes = req[16:0];
        it.align_bytes = al[16:0];
        it.user_offset_in = uo[15:0];
        return it;
    endfunction

    // directed opening sequence on the default layout
    function automatic t_in_item directed_cmd(int k);
        case (k)
            0:  return mk(CMD_ALLOC, 0, 1, 0, 0);
            1:  return mk(CMD_ALLOC, 0, 33, 0, 0);
            2:  return mk(CMD_ALLOC, 0, 65536, 0, 0);
            3:  return mk(CMD_ALLOC, 0, 0, 0, 0);
            4:  return mk(CMD_ALLOC, 0, 8, 3, 0);
            5:  return mk(CMD_ALLOC, 0, 0, 6, 0);
            6:  return mk(CMD_ALLOC, 0, 100, 64, 0);
            7:  return mk(CMD_ALLOC, 0, 64, 65536, 0);
            8:  return mk(CMD_FREE, 0, 0, 0, 16);
            9:  return mk(CMD_FREE, 0, 0, 0, 16);
            10: return mk(CMD_FREE, 0, 0, 0, 0);
            11: return mk(CMD_FREE, 0, 0, 0, 17);
            12: return mk(CMD_FREE, 0, 0, 0, 24);
            13: return mk(CMD_FREE, 0, 0, 0, 65535);
            14: return mk(CMD_FREE, 0, 0, 0, pick_live(0));
            15: return mk(CMD_STATS, 0, 0, 0, 0);
            16: return mk(CMD_ALLOC, 3, 64, 0, 0);
            17: return mk(CMD_FREE, 3, 0, 0, 16);
            18: return mk(CMD_RESET, 3, 0, 0, 0);
            19: return mk(CMD_STATS, 1, 0, 0, 0);
            20: return mk(CMD_RESET, 0, 0, 0, 0);
            21: return mk(CMD_ALLOC, 2, 65520, 16, 0);
            22: return mk(CMD_FREE, 2, 0, 0, 16);
            default: return mk(CMD_STATS, 2, 0, 0, 0);
        endcase
    endfunction

    // random command, mostly well formed alloc/free traffic
    function automatic t_in_item random_cmd();
        t_in_item it;
        int r, p;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = t_in_item'(raw[$bits(t_in_item)-1:0]);
        p = ($urandom_range(0, 31) == 0) ? 3 : $urandom_range(0, 2);
        it.pool_select = 2'(p);
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it.cmd = CMD_ALLOC;
            r = $urandom_range(0, 99);
            if (r < 70) it.request_bytes = 17'($urandom_range(1, 128));
            else if (r < 90) it.request_bytes = 17'($urandom_range(1, 2048));
            else if (r < 96) it.request_bytes = 17'($urandom_range(1, 65536));
            else if (r < 98) it.request_bytes = '0;
            else it.request_bytes = 17'd65536;
            r = $urandom_range(0, 99);
            if (r < 70) it.align_bytes = '0;
            else if (r < 90) it.align_bytes = 17'(1) << $urandom_range(0, 12);
            else if (r < 93) it.align_bytes = 17'd65536;
            else it.align_bytes = 17'($urandom_range(0, 65536));
        end else if (r < 82) begin
            it.cmd = CMD_FREE;
            r = $urandom_range(0, 99);
            if (r < 85 && p < 3 && sb.live[p].size() > 0)
                it.user_offset_in = 16'(pick_live(p));
            else if (r < 92 && p < 3) it.user_offset_in = 16'(sb.last_freed[p]);
            else it.user_offset_in = 16'($urandom_range(0, 65535));
        end else if (r < 86) begin
            it.cmd = CMD_RESET;
        end else begin
            it.cmd = CMD_STATS;
        end
        return it;
    endfunction

    task automatic run_random(int count, int ph);
        for (int k = 0; k < count; k++) begin
            if (k % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 3 && k == 40) hold_req = 1;
            if (ph == 2 && k == 120) drain();
            send_cmd(random_cmd());
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // default layout: directed then random
        for (int k = 0; k < 23; k++) send_cmd(directed_cmd(k));
        drain();
        run_random(200, 0);

        // smallest pool, top of range, odd bases
        reg_write(REG_CODE_BYTES, 32'd0);
        reg_write(REG_DATA_BYTES, 32'd512);
        reg_write(REG_META_BYTES, 32'h1FFFF);
        reg_write(REG_CODE_BASE, 32'hFFFF_FFFF);
        reg_write(REG_DATA_BASE, 32'd8);
        reg_write(REG_META_BASE, 32'h0000_1000);
        run_random(250, 1);

        // mid sizes, one not a multiple of 8, random bases
        reg_write(REG_CODE_BYTES, 32'd1000);
        reg_write(REG_DATA_BYTES, 32'd4100);
        reg_write(REG_META_BYTES, 32'd48);
        reg_write(REG_CODE_BASE, $urandom);
        reg_write(REG_DATA_BASE, $urandom);
        reg_write(REG_META_BASE, $urandom);
        run_random(250, 2);

        // largest pool again with long result hold
        reg_write(REG_CODE_BYTES, 32'd65536);
        reg_write(REG_DATA_BYTES, 32'd2000);
        reg_write(REG_META_BYTES, 32'd300);
        reg_write(REG_CODE_BASE, 32'd0);
        reg_write(REG_DATA_BASE, 32'd0);
        reg_write(REG_META_BASE, 32'h8000_0000);
        run_random(250, 3);

        repeat (50) @(posedge i_clk);
        $display("ran %0d commands over four pool layouts, %0d results checked",
                 n_sent, sb.checked);
        $display("%0d allocations and %0d releases succeeded", sb.good_allocs, sb.good_frees);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire
